[rtl/core/evdf_pkg.sv]
// Shared types and constants of the event word deframer.
`timescale 1ns / 1ps
`default_nettype none

package evdf_pkg;

    localparam int MAX_EVENT_WORDS = 64;
    localparam int ADDR_W          = $clog2(MAX_EVENT_WORDS);
    localparam int CNT_W           = $clog2(MAX_EVENT_WORDS + 1);

    localparam int WORD_W = 32;
    localparam int NUM_W  = 32;
    localparam int CHAN_W = 5;

    localparam int BASE_WORDS        = 5;
    localparam int WORDS_PER_CHANNEL = 3;
    localparam int EXP_MAX           = BASE_WORDS + WORDS_PER_CHANNEL * ((1 << CHAN_W) - 1);
    localparam int EXP_W             = $clog2(EXP_MAX + 1);
    localparam int CMP_W             = (EXP_W > CNT_W) ? EXP_W : CNT_W;

    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEAD_MARKER   = 2'd0,
        CFG_TAIL_MARKER   = 2'd1,
        CFG_CHANNEL_COUNT = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_HUNT    = 3'b001,
        S_COLLECT = 3'b010,
        S_DRAIN   = 3'b100
    } t_state;

    // One result word as it travels through the output queue.
    typedef struct packed {
        logic [NUM_W-1:0]  event_number;
        logic              last_word;
        logic [WORD_W-1:0] event_word;
    } t_out_word;

    typedef struct packed {
        logic       push;
        logic       pop;
        logic [1:0] count;
    } t_q_status;

endpackage

`default_nettype wire

[rtl/core/evdf_buf_ram.sv]
// Simple dual-port buffer RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module evdf_buf_ram #(
    parameter int DEPTH  = 64,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/core/evdf_out_q.sv]
// Two-entry output queue that decouples the buffer drain from the output stream.
`timescale 1ns / 1ps
`default_nettype none

module evdf_out_q
    import evdf_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  wire t_out_word i_data,
    output logic           o_valid,
    input  wire logic      i_ready,
    output t_out_word      o_data,
    output t_q_status      o_status
);

    t_out_word  r_mem [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count,  n_count;
    logic       w_pop;

    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_pop   = o_valid && i_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr ^ i_push;
        n_rd_ptr = r_rd_ptr ^ w_pop;
        n_count  = r_count + {1'b0, i_push} - {1'b0, w_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_status = '{push: i_push, pop: w_pop, count: r_count};

endmodule

`default_nettype wire

[rtl/core/event_word_deframer_core.sv]
// Top level of the event word deframer: framing control, buffer drain and output.
`timescale 1ns / 1ps
`default_nettype none

// The block hunts for a head marker word, collects the event into a 64-word buffer
// memory and, when a tail marker closes an event of exactly 5 + 3 * channel_count
// words, replays the event on the output stream with tlast on the tail word and the
// wrapping count of earlier good events in the upper half of tdata. While hunting or
// collecting one word is taken every cycle. A good event then occupies the buffer's
// read port, one read per word held back by output stalls, and no input word is taken
// until the last buffer read of that event has been issued; the output side reaches
// one word per cycle through a two-entry queue behind the registered RAM read.
// Events that are too long or of the wrong length are dropped silently. Configuration
// words are always accepted and should be written only while the block is idle.
module event_word_deframer_core
    import evdf_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // Slave stream, tdata: [31:0] data_word.
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    input  wire logic [WORD_W-1:0]    i_s_tdata,
    // Master stream, tdata: [31:0] event_word, [63:32] event_number.
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    output logic [WORD_W+NUM_W-1:0]   o_m_tdata,
    output logic                      o_m_tlast,
    // Configuration write channel.
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [WORD_W-1:0]    i_cfg_data
);

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_fill,  n_fill;
    logic [ADDR_W-1:0] r_len,   n_len;
    logic [ADDR_W-1:0] r_rd_idx, n_rd_idx;
    logic [NUM_W-1:0]  r_valid_events, n_valid_events;
    logic [WORD_W-1:0] r_head_marker;
    logic [WORD_W-1:0] r_tail_marker;
    logic [CHAN_W-1:0] r_channel_count;

    logic              r_rd_pend;
    logic              r_rd_last;
    logic [NUM_W-1:0]  r_rd_num;

    logic              w_in_acc;
    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    logic              w_issue;
    logic              w_issue_last;
    logic [CNT_W-1:0]  w_count_next;
    logic [CMP_W-1:0]  w_expected;
    logic [2:0]        w_occupancy;
    logic [WORD_W-1:0] w_rdata;
    t_out_word         w_push_data;
    t_out_word         w_out;
    t_q_status         w_q;

    // Configuration registers.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_marker   <= '0;
            r_tail_marker   <= '0;
            r_channel_count <= CHAN_W'(1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_HEAD_MARKER:   r_head_marker   <= i_cfg_data;
                CFG_TAIL_MARKER:   r_tail_marker   <= i_cfg_data;
                CFG_CHANNEL_COUNT: r_channel_count <= i_cfg_data[CHAN_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_s_tready = (r_state != S_DRAIN);
    assign w_in_acc   = i_s_tvalid && o_s_tready;

    assign w_count_next = r_fill + CNT_W'(1);
    assign w_expected   = CMP_W'(BASE_WORDS)
                        + CMP_W'(WORDS_PER_CHANNEL) * CMP_W'(r_channel_count);

    // Reads are issued only when the queue is sure to have room when the data lands.
    assign w_occupancy  = {1'b0, w_q.count} + {2'b00, r_rd_pend};
    assign w_issue      = (r_state == S_DRAIN)
                        && (w_occupancy < (3'd2 + {2'b00, w_q.pop}));
    assign w_issue_last = (r_rd_idx == r_len);

    always_comb begin
        n_state        = r_state;
        n_fill         = r_fill;
        n_len          = r_len;
        n_rd_idx       = r_rd_idx;
        n_valid_events = r_valid_events;
        w_we           = 1'b0;
        w_waddr        = r_fill[ADDR_W-1:0];
        unique case (r_state)
            S_HUNT: begin
                if (w_in_acc && (i_s_tdata == r_head_marker)) begin
                    w_we    = 1'b1;
                    w_waddr = '0;
                    n_fill  = CNT_W'(1);
                    n_state = S_COLLECT;
                end
            end
            S_COLLECT: begin
                if (w_in_acc) begin
                    w_we   = 1'b1;
                    n_fill = w_count_next;
                    if (w_count_next >= CNT_W'(MAX_EVENT_WORDS)) begin
                        n_state = S_HUNT;
                    end else if (i_s_tdata == r_tail_marker) begin
                        if (CMP_W'(w_count_next) == w_expected) begin
                            // r_len holds the index of the tail word.
                            n_len    = r_fill[ADDR_W-1:0];
                            n_rd_idx = '0;
                            n_state  = S_DRAIN;
                        end else begin
                            n_state = S_HUNT;
                        end
                    end
                end
            end
            S_DRAIN: begin
                if (w_issue) begin
                    n_rd_idx = r_rd_idx + ADDR_W'(1);
                    if (w_issue_last) begin
                        n_valid_events = r_valid_events + NUM_W'(1);
                        n_state        = S_HUNT;
                    end
                end
            end
            default: n_state = S_HUNT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_HUNT;
            r_fill         <= '0;
            r_len          <= '0;
            r_rd_idx       <= '0;
            r_valid_events <= '0;
            r_rd_pend      <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_fill         <= n_fill;
            r_len          <= n_len;
            r_rd_idx       <= n_rd_idx;
            r_valid_events <= n_valid_events;
            r_rd_pend      <= w_issue;
        end
    end

    // Tags are registered with the read, in step with the RAM data.
    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_rd_last <= w_issue_last;
            r_rd_num  <= r_valid_events;
        end
    end

    // The write port is used only outside the drain, so a read never meets a write.
    evdf_buf_ram #(
        .DEPTH  (MAX_EVENT_WORDS),
        .WIDTH  (WORD_W),
        .ADDR_W (ADDR_W)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (i_s_tdata),
        .i_re    (w_issue),
        .i_raddr (r_rd_idx),
        .o_rdata (w_rdata)
    );

    assign w_push_data = '{event_number: r_rd_num, last_word: r_rd_last, event_word: w_rdata};

    evdf_out_q u_out_q (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (r_rd_pend),
        .i_data   (w_push_data),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_data   (w_out),
        .o_status (w_q)
    );

    assign o_m_tdata = {w_out.event_number, w_out.event_word};
    assign o_m_tlast = w_out.last_word;

    // The queue never receives a word it has no room for.
    a_q_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q.push |-> (w_q.count != 2'd2) || w_q.pop)
        else $error("output queue overflow");

    // A drain never reads beyond the tail word of the event.
    a_rd_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_issue |-> (r_rd_idx <= r_len))
        else $error("buffer read beyond event length");

    // Leaving the drain always follows the read of the tail word.
    a_drain_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) && (n_state != S_DRAIN) |=> r_rd_pend && r_rd_last)
        else $error("drain ended without reading the tail word");

endmodule

`default_nettype wire
